// ===== src/digit_randomness_test_counters_defines.svh =====
// Assertion macros shared by the digit randomness test counter modules.
// Include this file by its bare name in any module that carries assertions.
`ifndef DIGIT_RANDOMNESS_TEST_COUNTERS_DEFINES_SVH
`define DIGIT_RANDOMNESS_TEST_COUNTERS_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DRTC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("drtc assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define DRTC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("drtc assertion failed");

`endif

// ===== src/drtc_pkg.sv =====
// Shared types, constants and the poker classifier for the digit test counters.
// Used by drtc_front, drtc_engine and the top level; depends on nothing.
package drtc_pkg;

    localparam int COUNT_BITS = 32;
    localparam int NUM_BINS   = 136;
    localparam int ADDR_W     = $clog2(NUM_BINS);
    localparam int MAX_OPS    = 5;

    localparam logic [ADDR_W-1:0] BIN_PAIR  = ADDR_W'(10);
    localparam logic [ADDR_W-1:0] BIN_POKER = ADDR_W'(110);
    localparam logic [ADDR_W-1:0] BIN_GAP   = ADDR_W'(117);

    localparam logic [4:0] GAP_A = 5'd16;
    localparam logic [4:0] GAP_B = 5'd21;
    localparam logic [4:0] GAP_C = 5'd26;

    localparam logic [3:0] DIGIT_MAX = 4'd9;
    localparam logic [2:0] SEEN_MAX  = 3'd5;

    localparam logic [2:0] PK_FIVE  = 3'd0;
    localparam logic [2:0] PK_FOUR  = 3'd1;
    localparam logic [2:0] PK_THREE = 3'd2;
    localparam logic [2:0] PK_PAIR  = 3'd3;
    localparam logic [2:0] PK_FULL  = 3'd4;
    localparam logic [2:0] PK_TWO   = 3'd5;
    localparam logic [2:0] PK_DIFF  = 3'd6;

    typedef logic [COUNT_BITS-1:0] t_count;
    typedef logic [3:0] t_digit;
    typedef logic [4:0][3:0] t_win;

    typedef enum logic [1:0] {
        REQ_PUSH,
        REQ_END,
        REQ_READ,
        REQ_CLEAR
    } t_req;

    typedef enum logic [1:0] {
        ST_OK,
        ST_SHORT,
        ST_BAD_INDEX
    } t_status;

    typedef enum logic [1:0] {
        OP_NOP,
        OP_BUMP,
        OP_READ,
        OP_CLEAR
    } t_op_kind;

    typedef struct packed {
        t_op_kind          kind;
        logic [ADDR_W-1:0] addr;
        logic              last;
        t_status           status;
    } t_op;

    typedef struct packed {
        logic vld;
        t_op  op;
    } t_issue;

    localparam t_op OP_IDLE = '{kind: OP_NOP, addr: '0, last: 1'b0, status: ST_OK};

    function automatic logic [2:0] poker_class(input t_win w);
        logic [2:0] mult [5];
        logic [2:0] distinct;
        logic [2:0] maxm;
        logic       first;
        distinct = 3'd0;
        maxm     = 3'd0;
        for (int i = 0; i < 5; i++) begin
            mult[i] = 3'd0;
            first   = 1'b1;
            for (int j = 0; j < 5; j++) begin
                if (w[j] == w[i]) begin
                    mult[i] = mult[i] + 3'd1;
                    if (j < i) begin
                        first = 1'b0;
                    end
                end
            end
            distinct = distinct + {2'b00, first};
            if (mult[i] > maxm) begin
                maxm = mult[i];
            end
        end
        case (distinct)
            3'd1:    poker_class = PK_FIVE;
            3'd2:    poker_class = (maxm == 3'd4) ? PK_FOUR : PK_FULL;
            3'd3:    poker_class = (maxm == 3'd3) ? PK_THREE : PK_TWO;
            3'd4:    poker_class = PK_PAIR;
            default: poker_class = PK_DIFF;
        endcase
    endfunction

    function automatic logic [ADDR_W-1:0] pair_addr(input t_digit a, input t_digit b);
        logic [ADDR_W-1:0] ax;
        ax = ADDR_W'(a);
        pair_addr = BIN_PAIR + (ax << 3) + (ax << 1) + ADDR_W'(b);
    endfunction

endpackage

// ===== src/digit_randomness_test_counters.sv =====
// Top level of the digit randomness test counters: decoder front end and bin engine.
// Depends on drtc_pkg, drtc_front, drtc_engine and drtc_ram.
//
// Channel   Valid         Stall         Payload
// request   i_in_valid    o_in_stall    i_req_type, i_digit, i_bin_index
// result    o_out_valid   i_out_stall   o_read_data, o_status
//
// A push is queued as one to four bin updates, an end of sequence as one op or five
// updates, a read or a clear as one op. The result is registered when the last op of
// a request leaves stage 1. Reset is synchronous; every bin reads as zero at once
// through per-bin valid flags. New requests wait until the queue drains; a stalled
// result freezes the update pipeline once the next request's last op reaches stage 1.
module digit_randomness_test_counters (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_req_type,
    input  logic [3:0]  i_digit,
    input  logic [7:0]  i_bin_index,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_read_data,
    output logic [1:0]  o_status
);

    drtc_pkg::t_issue issue;
    logic             advance;

    drtc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_req_type  (i_req_type),
        .i_digit     (i_digit),
        .i_bin_index (i_bin_index),
        .i_advance   (advance),
        .o_issue     (issue)
    );

    drtc_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_issue     (issue),
        .o_advance   (advance),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_read_data (o_read_data),
        .o_status    (o_status)
    );

endmodule

// ===== src/drtc_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module drtc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 136
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/drtc_front.sv =====
// Request decoder, sequence state and op queue for the digit test counters.
// Depends on drtc_pkg and the assertion macros header.
`include "digit_randomness_test_counters_defines.svh"

module drtc_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [1:0]            i_req_type,
    input  logic [3:0]            i_digit,
    input  logic [7:0]            i_bin_index,
    input  logic                  i_advance,
    output drtc_pkg::t_issue      o_issue
);

    drtc_pkg::t_op    r_ops [drtc_pkg::MAX_OPS];
    drtc_pkg::t_op    n_ops [drtc_pkg::MAX_OPS];
    drtc_pkg::t_op    lst   [drtc_pkg::MAX_OPS];
    drtc_pkg::t_op    cand  [drtc_pkg::MAX_OPS];
    logic [drtc_pkg::MAX_OPS-1:0] cand_vld;
    logic [2:0]       r_cnt;
    logic [2:0]       n_cnt;
    logic [2:0]       lst_n;

    drtc_pkg::t_digit r_recent [4];
    drtc_pkg::t_digit n_recent [4];
    drtc_pkg::t_digit r_first  [4];
    drtc_pkg::t_digit n_first  [4];
    logic [2:0]       r_seen;
    logic [2:0]       n_seen;
    logic [4:0]       r_gap;
    logic [4:0]       n_gap;
    logic             r_zero;
    logic             n_zero;

    drtc_pkg::t_req    req;
    drtc_pkg::t_status stat;
    drtc_pkg::t_win    push_win;
    drtc_pkg::t_win    end_win [4];
    drtc_pkg::t_digit  ring [8];
    logic [drtc_pkg::ADDR_W-1:0] gap_addr;
    logic              digit_ok;
    logic              accept;
    logic              issue;

    assign req      = drtc_pkg::t_req'(i_req_type);
    assign digit_ok = (i_digit <= drtc_pkg::DIGIT_MAX);
    assign issue    = (r_cnt != 3'd0) && i_advance;
    assign o_in_stall = !((r_cnt == 3'd0) || ((r_cnt == 3'd1) && i_advance));
    assign accept   = i_in_valid && !o_in_stall;

    assign o_issue.vld = (r_cnt != 3'd0);
    assign o_issue.op  = r_ops[0];

    always_comb begin
        push_win = {i_digit, r_recent[3], r_recent[2], r_recent[1], r_recent[0]};
        for (int i = 0; i < 4; i++) begin
            ring[i]     = r_recent[i];
            ring[i + 4] = r_first[i];
        end
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 5; j++) begin
                end_win[i][j] = ring[i + j];
            end
        end
        if (r_gap < drtc_pkg::GAP_A) begin
            gap_addr = drtc_pkg::BIN_GAP + drtc_pkg::ADDR_W'(r_gap);
        end else if (r_gap < drtc_pkg::GAP_B) begin
            gap_addr = drtc_pkg::BIN_GAP + drtc_pkg::ADDR_W'(16);
        end else if (r_gap < drtc_pkg::GAP_C) begin
            gap_addr = drtc_pkg::BIN_GAP + drtc_pkg::ADDR_W'(17);
        end else begin
            gap_addr = drtc_pkg::BIN_GAP + drtc_pkg::ADDR_W'(18);
        end
    end

    always_comb begin
        stat = drtc_pkg::ST_OK;
        for (int k = 0; k < drtc_pkg::MAX_OPS; k++) begin
            cand[k] = drtc_pkg::OP_IDLE;
        end
        cand_vld = '0;
        case (req)
            drtc_pkg::REQ_PUSH: begin
                if (digit_ok) begin
                    cand[0].kind = drtc_pkg::OP_BUMP;
                    cand[0].addr = drtc_pkg::ADDR_W'(i_digit);
                    cand_vld[0]  = 1'b1;
                    cand[1].kind = drtc_pkg::OP_BUMP;
                    cand[1].addr = drtc_pkg::pair_addr(r_recent[3], i_digit);
                    cand_vld[1]  = (r_seen >= 3'd1);
                    cand[2].kind = drtc_pkg::OP_BUMP;
                    cand[2].addr = drtc_pkg::BIN_POKER
                                 + drtc_pkg::ADDR_W'(drtc_pkg::poker_class(push_win));
                    cand_vld[2]  = (r_seen >= 3'd4);
                    cand[3].kind = drtc_pkg::OP_BUMP;
                    cand[3].addr = gap_addr;
                    cand_vld[3]  = (i_digit == 4'd0) && r_zero;
                end
            end
            drtc_pkg::REQ_END: begin
                if (r_seen >= drtc_pkg::SEEN_MAX) begin
                    cand[0].kind = drtc_pkg::OP_BUMP;
                    cand[0].addr = drtc_pkg::pair_addr(r_recent[3], r_first[0]);
                    cand_vld[0]  = 1'b1;
                    for (int i = 0; i < 4; i++) begin
                        cand[i + 1].kind = drtc_pkg::OP_BUMP;
                        cand[i + 1].addr = drtc_pkg::BIN_POKER
                            + drtc_pkg::ADDR_W'(drtc_pkg::poker_class(end_win[i]));
                        cand_vld[i + 1]  = 1'b1;
                    end
                end else begin
                    stat = drtc_pkg::ST_SHORT;
                end
            end
            drtc_pkg::REQ_READ: begin
                if (i_bin_index < 8'(drtc_pkg::NUM_BINS)) begin
                    cand[0].kind = drtc_pkg::OP_READ;
                    cand[0].addr = drtc_pkg::ADDR_W'(i_bin_index);
                    cand_vld[0]  = 1'b1;
                end else begin
                    stat = drtc_pkg::ST_BAD_INDEX;
                end
            end
            drtc_pkg::REQ_CLEAR: begin
                cand[0].kind = drtc_pkg::OP_CLEAR;
                cand_vld[0]  = 1'b1;
            end
            default: begin
                stat = drtc_pkg::ST_OK;
            end
        endcase
    end

    always_comb begin
        for (int k = 0; k < drtc_pkg::MAX_OPS; k++) begin
            lst[k] = drtc_pkg::OP_IDLE;
        end
        lst_n = 3'd0;
        for (int k = 0; k < drtc_pkg::MAX_OPS; k++) begin
            if (cand_vld[k]) begin
                lst[lst_n] = cand[k];
                lst_n = lst_n + 3'd1;
            end
        end
        if (lst_n == 3'd0) begin
            lst_n = 3'd1;
        end
        for (int k = 0; k < drtc_pkg::MAX_OPS; k++) begin
            lst[k].status = stat;
        end
        lst[lst_n - 3'd1].last = 1'b1;
    end

    always_comb begin
        n_ops = r_ops;
        n_cnt = r_cnt;
        if (issue) begin
            for (int k = 0; k < drtc_pkg::MAX_OPS - 1; k++) begin
                n_ops[k] = r_ops[k + 1];
            end
            n_cnt = r_cnt - 3'd1;
        end
        if (accept) begin
            n_ops = lst;
            n_cnt = lst_n;
        end
    end

    always_comb begin
        n_recent = r_recent;
        n_first  = r_first;
        n_seen   = r_seen;
        n_gap    = r_gap;
        n_zero   = r_zero;
        case (req)
            drtc_pkg::REQ_PUSH: begin
                if (digit_ok) begin
                    if (i_digit == 4'd0) begin
                        n_zero = 1'b1;
                        n_gap  = 5'd0;
                    end else if (r_zero && (r_gap < drtc_pkg::GAP_C)) begin
                        n_gap = r_gap + 5'd1;
                    end
                    if (r_seen < 3'd4) begin
                        n_first[r_seen[1:0]] = i_digit;
                    end
                    for (int i = 0; i < 3; i++) begin
                        n_recent[i] = r_recent[i + 1];
                    end
                    n_recent[3] = i_digit;
                    if (r_seen < drtc_pkg::SEEN_MAX) begin
                        n_seen = r_seen + 3'd1;
                    end
                end
            end
            drtc_pkg::REQ_END, drtc_pkg::REQ_CLEAR: begin
                for (int i = 0; i < 4; i++) begin
                    n_recent[i] = 4'd0;
                    n_first[i]  = 4'd0;
                end
                n_seen = 3'd0;
                n_gap  = 5'd0;
                n_zero = 1'b0;
            end
            default: begin
                n_seen = r_seen;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= 3'd0;
            r_seen <= 3'd0;
            r_gap  <= 5'd0;
            r_zero <= 1'b0;
            for (int i = 0; i < 4; i++) begin
                r_recent[i] <= 4'd0;
                r_first[i]  <= 4'd0;
            end
        end else begin
            r_cnt <= n_cnt;
            if (accept) begin
                r_recent <= n_recent;
                r_first  <= n_first;
                r_seen   <= n_seen;
                r_gap    <= n_gap;
                r_zero   <= n_zero;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ops <= n_ops;
    end

    `DRTC_ASSERT_NEXT(a_load_nonempty, i_clk, i_rst_n, accept, r_cnt != 3'd0)
    `DRTC_ASSERT_IMPL(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= 3'(drtc_pkg::MAX_OPS))
    `DRTC_ASSERT_IMPL(a_addr_range, i_clk, i_rst_n, o_issue.vld && (o_issue.op.kind == drtc_pkg::OP_BUMP || o_issue.op.kind == drtc_pkg::OP_READ), o_issue.op.addr < drtc_pkg::ADDR_W'(drtc_pkg::NUM_BINS))

endmodule

// ===== src/drtc_engine.sv =====
// Read-modify-write engine over the bin memory, with forwarding and the result register.
// Depends on drtc_pkg, drtc_ram and the assertion macros header.
`include "digit_randomness_test_counters_defines.svh"

module drtc_engine (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  drtc_pkg::t_issue i_issue,
    output logic             o_advance,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [31:0]      o_read_data,
    output logic [1:0]       o_status
);

    logic                        r_s1_vld;
    drtc_pkg::t_op               r_s1_op;
    logic                        r_s1_vbit;
    logic                        r_wr_vld;
    logic                        r_wr_clr;
    logic [drtc_pkg::ADDR_W-1:0] r_wr_addr;
    drtc_pkg::t_count            r_wr_data;
    logic [drtc_pkg::NUM_BINS-1:0] r_bin_vld;
    logic                        r_out_vld;
    logic [31:0]                 r_out_data;
    drtc_pkg::t_status           r_out_status;

    drtc_pkg::t_count            rdata;
    drtc_pkg::t_count            base;
    drtc_pkg::t_count            bumped;
    logic                        hold;
    logic                        advance;
    logic                        we;
    logic                        s1_clear;
    logic                        s1_done;

    drtc_ram #(
        .WIDTH (drtc_pkg::COUNT_BITS),
        .DEPTH (drtc_pkg::NUM_BINS)
    ) u_bins (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_s1_op.addr),
        .i_wdata (bumped),
        .i_re    (advance),
        .i_raddr (i_issue.op.addr),
        .o_rdata (rdata)
    );

    always_comb begin
        hold     = r_s1_vld && r_s1_op.last && r_out_vld && i_out_stall;
        advance  = !hold;
        s1_done  = advance && r_s1_vld && r_s1_op.last;
        we       = advance && r_s1_vld && (r_s1_op.kind == drtc_pkg::OP_BUMP);
        s1_clear = advance && r_s1_vld && (r_s1_op.kind == drtc_pkg::OP_CLEAR);
        if (r_wr_clr) begin
            base = '0;
        end else if (r_wr_vld && (r_wr_addr == r_s1_op.addr)) begin
            base = r_wr_data;
        end else if (r_s1_vbit) begin
            base = rdata;
        end else begin
            base = '0;
        end
        bumped = (&base) ? base : base + drtc_pkg::COUNT_BITS'(1);
    end

    assign o_advance   = advance;
    assign o_out_valid = r_out_vld;
    assign o_read_data = r_out_data;
    assign o_status    = r_out_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_wr_vld  <= 1'b0;
            r_wr_clr  <= 1'b0;
            r_bin_vld <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (advance) begin
                r_s1_vld <= i_issue.vld;
                r_wr_vld <= we;
                r_wr_clr <= s1_clear;
            end
            if (s1_clear) begin
                r_bin_vld <= '0;
            end else if (we) begin
                r_bin_vld[r_s1_op.addr] <= 1'b1;
            end
            if (s1_done) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s1_op   <= i_issue.op;
            r_s1_vbit <= r_bin_vld[i_issue.op.addr];
            r_wr_addr <= r_s1_op.addr;
            r_wr_data <= bumped;
        end
        if (s1_done) begin
            r_out_data   <= (r_s1_op.kind == drtc_pkg::OP_READ) ? 32'(base) : 32'd0;
            r_out_status <= r_s1_op.status;
        end
    end

    `DRTC_ASSERT_NEXT(a_hold_freezes, i_clk, i_rst_n, hold, r_s1_vld && $stable(r_s1_op))
    `DRTC_ASSERT_IMPL(a_fwd_exclusive, i_clk, i_rst_n, r_wr_clr, !r_wr_vld)
    `DRTC_ASSERT_IMPL(a_result_source, i_clk, i_rst_n, $rose(r_out_vld), $past(r_s1_vld && r_s1_op.last))
    `DRTC_ASSERT_IMPL(a_data_zero, i_clk, i_rst_n, r_out_vld && r_out_status != drtc_pkg::ST_OK, r_out_data == 32'd0)

endmodule
